@@ rtl/core/rsa_pkg.sv @@
// Package for the reference-counted slot allocator.
// Holds field widths, default sizes, request/status codes and queue entry types.
// No dependencies.
package rsa_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int COUNT_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 2;
  localparam int REFS_W = 8;
  localparam int OCC_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RETAIN  = 2'd1,
    REQ_RELEASE = 2'd2
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_FREE_REL = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  granted_slot;
    logic [REFS_W-1:0] slot_refs;
    logic [OCC_W-1:0]  occupied;
    logic              is_empty;
    logic              is_full;
  } res_t;

endpackage

@@ rtl/core/refcounted_slot_allocator_top.sv @@
// Reference-counted slot allocator with next-fit allocation: the engine handles
// a transaction as a registered read of the slot's count memory, then a
// write-back with bitmap and counter update, one transaction at a time, and
// takes a new request only after the last one is written back and only while
// the result queue has room. Request and result queues of rsa_pkg::QUEUE_DEPTH
// entries decouple the sides. Slot counts of free slots are masked by an
// occupancy bitmap, so no clearing pass runs after reset.
// Depends on rsa_pkg, rsa_fifo, rsa_engine.
module refcounted_slot_allocator_top #(
  parameter int SLOTS      = rsa_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [rsa_pkg::REQ_W-1:0]   req_type_i,
  input  logic [rsa_pkg::IDX_W-1:0]   slot_index_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [rsa_pkg::ST_W-1:0]    status_o,
  output logic [rsa_pkg::IDX_W-1:0]   granted_slot_o,
  output logic [rsa_pkg::REFS_W-1:0]  slot_refs_o,
  output logic [rsa_pkg::OCC_W-1:0]   occupied_o,
  output logic                        is_empty_o,
  output logic                        is_full_o
);

  rsa_pkg::req_t req_in, req_out;
  rsa_pkg::res_t res_in, res_out;
  logic          req_empty, req_pop;
  logic          res_full, res_push;

  assign req_in.req_type   = req_type_i;
  assign req_in.slot_index = slot_index_i;

  rsa_fifo #(
    .W     ($bits(rsa_pkg::req_t)),
    .DEPTH (rsa_pkg::QUEUE_DEPTH)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (req_in),
    .full_o  (full),
    .pop_i   (req_pop),
    .data_o  (req_out),
    .empty_o (req_empty)
  );

  rsa_engine #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (!req_empty),
    .req_i       (req_out),
    .req_pop_o   (req_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  rsa_fifo #(
    .W     ($bits(rsa_pkg::res_t)),
    .DEPTH (rsa_pkg::QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o       = res_out.status;
  assign granted_slot_o = res_out.granted_slot;
  assign slot_refs_o    = res_out.slot_refs;
  assign occupied_o     = res_out.occupied;
  assign is_empty_o     = res_out.is_empty;
  assign is_full_o      = res_out.is_full;

endmodule

@@ rtl/core/rsa_fifo.sv @@
// Small register queue used on both sides of the allocator engine.
// Generic width and depth; no package dependencies.
module rsa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/rsa_engine.sv @@
// Allocator back end: count memory, occupancy bitmap, next-fit pointer.
// Two-step read-modify-write per transaction. Depends on rsa_pkg.
module rsa_engine #(
  parameter int SLOTS      = rsa_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  rsa_pkg::req_t req_i,
  output logic         req_pop_o,
  input  logic         res_ready_i,
  output logic         res_push_o,
  output rsa_pkg::res_t res_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OW = $clog2(SLOTS + 1);
  localparam int CW = COUNT_BITS;
  localparam int XW = (IW > rsa_pkg::IDX_W) ? IW : rsa_pkg::IDX_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  logic [SLOTS-1:0] occ_q, occ_d;
  logic [OW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    ptr_q, ptr_d;

  logic [rsa_pkg::REQ_W-1:0] kind_q;
  logic [IW-1:0]             addr_q;
  logic                      idx_ok_q;
  logic [IW-1:0]             probe_q;

  logic [CW-1:0] cnt_mem_q [SLOTS];
  logic [CW-1:0] rd_q;

  logic             start, exec;
  logic [XW-1:0]    idx_ext;
  logic [IW-1:0]    raddr;
  logic             idx_ok;
  logic [SLOTS-1:0] free, ge_mask, upper, pick, first;
  logic [IW-1:0]    probe;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [CW-1:0]         wdata, cur, refs;
  logic [IW-1:0]         gslot;
  rsa_pkg::status_e      st;

  assign start     = (state_q == S_IDLE) && req_valid_i && res_ready_i;
  assign exec      = (state_q == S_EXEC);
  assign req_pop_o = start;
  assign idx_ext   = XW'(req_i.slot_index);
  assign raddr     = idx_ext[IW-1:0];
  assign idx_ok    = (32'(req_i.slot_index) < 32'(SLOTS));

  // rotating first-free search from the next-fit pointer
  always_comb begin
    free = ~occ_q;
    for (int i = 0; i < SLOTS; i++) begin
      ge_mask[i] = (IW'(i) >= ptr_q);
    end
    upper = free & ge_mask;
    pick  = (|upper) ? upper : free;
    first = pick & (~pick + SLOTS'(1));
    probe = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i]) begin
        probe = probe | IW'(i);
      end
    end
  end

  always_comb begin
    cur   = occ_q[addr_q] ? rd_q : '0;
    we    = 1'b0;
    waddr = addr_q;
    wdata = cur;
    occ_d = occ_q;
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    st    = rsa_pkg::ST_OK;
    gslot = '0;
    refs  = '0;
    case (kind_q)
      rsa_pkg::REQ_ALLOC: begin
        if (cnt_q == OW'(SLOTS)) begin
          st = rsa_pkg::ST_FULL;
        end else begin
          we             = 1'b1;
          waddr          = probe_q;
          wdata          = CW'(1);
          occ_d[probe_q] = 1'b1;
          cnt_d          = cnt_q + OW'(1);
          ptr_d          = (probe_q == IW'(SLOTS - 1)) ? '0 : probe_q + IW'(1);
          gslot          = probe_q;
          refs           = CW'(1);
        end
      end
      rsa_pkg::REQ_RETAIN: begin
        if (idx_ok_q) begin
          if (cur == CNT_MAX) begin
            st   = rsa_pkg::ST_SAT;
            refs = CNT_MAX;
          end else begin
            we            = 1'b1;
            wdata         = cur + CW'(1);
            occ_d[addr_q] = 1'b1;
            if (cur == '0) begin
              cnt_d = cnt_q + OW'(1);
            end
            refs = cur + CW'(1);
          end
        end
      end
      rsa_pkg::REQ_RELEASE: begin
        if (idx_ok_q) begin
          if (cur == '0) begin
            st = rsa_pkg::ST_FREE_REL;
          end else begin
            we    = 1'b1;
            wdata = cur - CW'(1);
            refs  = cur - CW'(1);
            if (cur == CW'(1)) begin
              occ_d[addr_q] = 1'b0;
              cnt_d         = cnt_q - OW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_push_o         = exec;
  assign res_o.status       = st;
  assign res_o.granted_slot = rsa_pkg::IDX_W'(gslot);
  assign res_o.slot_refs    = rsa_pkg::REFS_W'(refs);
  assign res_o.occupied     = rsa_pkg::OCC_W'(cnt_d);
  assign res_o.is_empty     = (cnt_d == '0);
  assign res_o.is_full      = (cnt_d == OW'(SLOTS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        occ_q <= occ_d;
        cnt_q <= cnt_d;
        ptr_q <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      kind_q   <= req_i.req_type;
      addr_q   <= raddr;
      idx_ok_q <= idx_ok;
      probe_q  <= probe;
    end
  end

  // count memory; entries of free slots read as zero through occ_q
  always_ff @(posedge clk_i) begin
    if (exec && we) begin
      cnt_mem_q[waddr] <= wdata;
    end
    rd_q <= cnt_mem_q[raddr];
  end

endmodule

@@ rtl/core/rsa_checker.sv @@
// Port-level checker for the slot allocator, bound to the top level.
// Depends on rsa_pkg and refcounted_slot_allocator_top.
module rsa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic [rsa_pkg::REQ_W-1:0]   req_type_i,
  input logic [rsa_pkg::IDX_W-1:0]   slot_index_i,
  input logic                        empty,
  input logic                        pop,
  input logic [rsa_pkg::ST_W-1:0]    status_o,
  input logic [rsa_pkg::IDX_W-1:0]   granted_slot_o,
  input logic [rsa_pkg::REFS_W-1:0]  slot_refs_o,
  input logic [rsa_pkg::OCC_W-1:0]   occupied_o,
  input logic                        is_empty_o,
  input logic                        is_full_o
);

  a_full_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == rsa_pkg::ST_FULL) |->
      (granted_slot_o == '0 && slot_refs_o == '0 && is_full_o))
    else $error("full status with grant or refs");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (is_empty_o == (occupied_o == '0)))
    else $error("is_empty disagrees with occupied");

  a_grant_one_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && granted_slot_o != '0) |->
      (status_o == rsa_pkg::ST_OK && slot_refs_o == rsa_pkg::REFS_W'(1) && !is_empty_o))
    else $error("grant without ok status and one reference");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(occupied_o)))
    else $error("waiting result changed");

endmodule

bind refcounted_slot_allocator_top rsa_checker u_rsa_checker (.*);
